// ===== sv/stream_pattern_replace_unit_assert.svh =====
// Assertion macros for the stream pattern replace unit.
`ifndef STREAM_PATTERN_REPLACE_UNIT_ASSERT_SVH
`define STREAM_PATTERN_REPLACE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define SPR_ASSERT_NOW(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("spr assertion failed");
`define SPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spr assertion failed");
`else
`define SPR_ASSERT_NOW(lbl, expr)
`define SPR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/spr_pkg.sv =====
`timescale 1ns / 1ps
package spr_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int OUT_DEPTH       = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
                                                                   : MAX_REPLACEMENT;
  localparam int LEN_W  = 4;
  localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES,
    REG_PATTERN_LENGTH,
    REG_REPLACEMENT_BYTES,
    REG_REPLACEMENT_LENGTH
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_word_t;

  typedef struct packed {
    logic wr;
    logic from_nbr;
    logic use_in;
    logic active;
  } cell_ctrl_t;

  typedef logic [OUT_DEPTH-1:0][7:0] out_bytes_t;

endpackage

// ===== sv/stream_pattern_replace_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Word
// cfg       in         psel/penable       APB register write and read, 64-bit data
// in        in         in_valid/in_stall  in_byte, in_last
// out       out        out_valid/out_stall out_byte, out_last
//
// One source byte is taken per cycle while each byte yields at most one result and
// out_stall is low. A byte that yields n results (a replacement or a final flush)
// holds the input until the output line, draining one byte per unstalled cycle, holds one.
// Reset is synchronous and empties the window and the output line; no clearing pass.
// Any register write empties the window.
`include "stream_pattern_replace_unit_assert.svh"
module stream_pattern_replace_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spr_pkg::ADDR_W-1:0]   paddr,
  input  logic [spr_pkg::DATA_W-1:0]   pwdata,
  output logic [spr_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  spr_pkg::in_word_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output spr_pkg::out_word_t           out_data
);

  localparam int NP = spr_pkg::MAX_PATTERN;
  localparam int LW = spr_pkg::LEN_W;
  localparam int CW = spr_pkg::CNT_W;

  logic [8*NP-1:0]                       pattern_bytes;
  logic [LW-1:0]                         pattern_length;
  logic [8*spr_pkg::MAX_REPLACEMENT-1:0] replacement_bytes;
  logic [LW-1:0]                         replacement_length;
  logic [LW-1:0]                         fill;
  logic [LW-1:0]                         fill_next;

  spr_pkg::reg_idx_t    cfg_idx;
  logic                 cfg_wr;
  logic [LW-1:0]        plen;
  logic [LW-1:0]        rlen;
  logic [LW-1:0]        fill_inc;
  logic                 enabled;
  logic                 full;
  logic                 match;
  logic                 hit;
  logic                 in_accept;

  spr_pkg::cell_ctrl_t  ctrl [NP];
  logic [7:0]           held [NP];
  logic [7:0]           view [NP];
  logic [NP:0]          mchain;

  spr_pkg::out_bytes_t  load_bytes;
  logic [CW-1:0]        load_cnt;
  logic [CW-1:0]        out_count;

  assign pready  = 1'b1;
  assign cfg_idx = spr_pkg::reg_idx_t'(paddr[spr_pkg::ADDR_W-1:3]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= '0;
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        spr_pkg::REG_PATTERN_BYTES:      pattern_bytes      <= pwdata;
        spr_pkg::REG_PATTERN_LENGTH:     pattern_length     <= pwdata[LW-1:0];
        spr_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes  <= pwdata;
        spr_pkg::REG_REPLACEMENT_LENGTH: replacement_length <= pwdata[LW-1:0];
        default:                         pattern_length     <= pattern_length;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      spr_pkg::REG_PATTERN_BYTES:      prdata = pattern_bytes;
      spr_pkg::REG_PATTERN_LENGTH:     prdata = spr_pkg::DATA_W'(pattern_length);
      spr_pkg::REG_REPLACEMENT_BYTES:  prdata = replacement_bytes;
      spr_pkg::REG_REPLACEMENT_LENGTH: prdata = spr_pkg::DATA_W'(replacement_length);
      default:                         prdata = '0;
    endcase
  end

  assign plen = (pattern_length > LW'(NP)) ? LW'(NP) : pattern_length;
  assign rlen = (replacement_length > LW'(spr_pkg::MAX_REPLACEMENT))
                ? LW'(spr_pkg::MAX_REPLACEMENT) : replacement_length;

  assign enabled   = (plen != '0) & (rlen != '0);
  assign fill_inc  = fill + LW'(1);
  assign full      = (fill_inc == plen);
  assign in_accept = in_valid & !in_stall;
  assign match     = mchain[NP];
  assign hit       = enabled & full & match;
  assign mchain[0] = 1'b1;

  for (genvar i = 0; i < NP; i++) begin : g_cell
    logic [7:0] nbr;
    if (i == NP - 1) begin : g_end
      assign nbr = 8'h00;
    end else begin : g_mid
      assign nbr = held[i+1];
    end

    always_comb begin
      ctrl[i].use_in   = (fill == LW'(i));
      ctrl[i].active   = (LW'(i) < plen);
      ctrl[i].from_nbr = full & (LW'(i + 1) < fill);
      ctrl[i].wr       = in_accept & enabled & !in_data.in_last &
                         ((!full & (fill == LW'(i))) | (full & !match & (LW'(i) < fill)));
    end

    spr_cell u_cell (
      .clk       (clk),
      .in_byte   (in_data.in_byte),
      .nbr_byte  (nbr),
      .pat_byte  (pattern_bytes[8*i +: 8]),
      .ctrl      (ctrl[i]),
      .match_in  (mchain[i]),
      .held      (held[i]),
      .view      (view[i]),
      .match_out (mchain[i+1])
    );
  end

  always_comb begin
    load_bytes = '0;
    for (int j = 0; j < NP; j++) begin
      load_bytes[j] = view[j];
    end
    if (!enabled) begin
      load_bytes    = '0;
      load_bytes[0] = in_data.in_byte;
      load_cnt      = CW'(1);
    end else if (hit) begin
      load_bytes = '0;
      for (int j = 0; j < spr_pkg::MAX_REPLACEMENT; j++) begin
        load_bytes[j] = replacement_bytes[8*j +: 8];
      end
      load_cnt = CW'(rlen);
    end else if (in_data.in_last) begin
      load_cnt = CW'(fill_inc);
    end else begin
      load_cnt = full ? CW'(1) : CW'(0);
    end
  end

  always_comb begin
    priority if (!enabled || in_data.in_last || hit) begin
      fill_next = '0;
    end else if (full) begin
      fill_next = fill;
    end else begin
      fill_next = fill_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cfg_wr) begin
      fill <= '0;
    end else if (in_accept) begin
      fill <= fill_next;
    end
  end

  assign in_stall = (out_count > CW'(1)) | ((out_count == CW'(1)) & out_stall);

  spr_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (in_accept),
    .load_bytes (load_bytes),
    .load_cnt   (load_cnt),
    .load_last  (in_data.in_last),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .count      (out_count)
  );

  `SPR_ASSERT_NEXT(a_last_empties, in_accept && in_data.in_last, fill == '0)
  `SPR_ASSERT_NOW(a_fill_bound, !enabled || (fill < plen))
  `SPR_ASSERT_NEXT(a_repl_count, in_accept && hit && !cfg_wr, out_count == CW'(rlen))

endmodule

// ===== sv/spr_cell.sv =====
`timescale 1ns / 1ps
module spr_cell (
  input  logic                clk,
  input  logic [7:0]          in_byte,
  input  logic [7:0]          nbr_byte,
  input  logic [7:0]          pat_byte,
  input  spr_pkg::cell_ctrl_t ctrl,
  input  logic                match_in,
  output logic [7:0]          held,
  output logic [7:0]          view,
  output logic                match_out
);

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      held <= ctrl.from_nbr ? nbr_byte : in_byte;
    end
  end

  assign view      = ctrl.use_in ? in_byte : held;
  assign match_out = match_in & (!ctrl.active | (view == pat_byte));

endmodule

// ===== sv/spr_out_stage.sv =====
`timescale 1ns / 1ps
module spr_out_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  spr_pkg::out_bytes_t           load_bytes,
  input  logic [spr_pkg::CNT_W-1:0]     load_cnt,
  input  logic                          load_last,
  input  logic                          out_stall,
  output logic                          out_valid,
  output spr_pkg::out_word_t            out_data,
  output logic [spr_pkg::CNT_W-1:0]     count
);

  spr_pkg::out_bytes_t           bytes;
  spr_pkg::out_bytes_t           bytes_next;
  logic [spr_pkg::CNT_W-1:0]     count_next;
  logic                          last_flag;
  logic                          last_flag_next;
  logic                          pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid & !out_stall;

  always_comb begin
    bytes_next     = bytes;
    count_next     = count;
    last_flag_next = last_flag;
    if (load) begin
      bytes_next     = load_bytes;
      count_next     = load_cnt;
      last_flag_next = load_last;
    end else if (pop) begin
      bytes_next = bytes >> 8;
      count_next = count - spr_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      last_flag <= 1'b0;
    end else begin
      count     <= count_next;
      last_flag <= last_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    bytes <= bytes_next;
  end

  assign out_data.out_byte = bytes[0];
  assign out_data.out_last = last_flag & (count == spr_pkg::CNT_W'(1));

endmodule
